FILE: hw/rtl/stcpd_pkg.sv
// shared types, constants and helpers for the space-time core point detector
package stcpd_pkg;

    localparam int MAX_ROWS_DEF    = 128;
    localparam int MAX_COLS_DEF    = 512;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 10;
    localparam int THR_W   = 5;
    localparam int DIV_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 5;
    localparam int OROW_W  = 7;
    localparam int OCOL_W  = 9;
    localparam int IDX_W   = 2;

    localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(120);
    localparam logic [COL_W-1:0] COLS_RESET = COL_W'(360);
    localparam logic [THR_W-1:0] THR_RESET  = THR_W'(9);
    localparam logic [DIV_W-1:0] DIV_RESET  = DIV_W'(1);

    // register indexes
    localparam logic [IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [IDX_W-1:0] REG_THR  = 2'd2;
    localparam logic [IDX_W-1:0] REG_DIV  = 2'd3;

    // window taps: 0 is the centre, 1..8 the neighbours
    localparam int TAPS = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    // divider control between sequencer and divider
    typedef struct packed {
        logic                    start;
        logic [DIV_W-1:0]        dividend;
        logic [DIV_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [DIV_W-1:0]        quotient;
    } div_rsp_t;

    function automatic logic signed [2:0] tap_dr(input logic [3:0] t);
        logic signed [2:0] d;
        d = 3'sd0;
        unique case (t)
            4'd1, 4'd2, 4'd8: d = -3'sd1;
            4'd4, 4'd5, 4'd6: d = 3'sd1;
            default:          d = 3'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [2:0] tap_dc(input logic [3:0] t);
        logic signed [2:0] d;
        d = 3'sd0;
        unique case (t)
            4'd2, 4'd3, 4'd4: d = 3'sd1;
            4'd6, 4'd7, 4'd8: d = -3'sd1;
            default:          d = 3'sd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/stcpd_ram.sv
// generic single-port-write, single-port-read ram with registered read
module stcpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/stcpd_div.sv
// restoring radix-2 divider, one quotient bit per cycle
module stcpd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  stcpd_pkg::div_req_t req,
    output stcpd_pkg::div_rsp_t rsp
);

    localparam int W = stcpd_pkg::DIV_W;

    logic [W-1:0]         quo_reg, quo_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         dsr_reg, dsr_next;
    logic [$clog2(W):0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [W:0]           trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // shift-subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = (req.divisor == '0) ? W'(1) : req.divisor;
            cnt_next  = ($clog2(W)+1)'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ($clog2(W)+1)'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // a finished division is never reported while still shifting
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

FILE: hw/rtl/spacetime_core_point_detect_core.sv
// space-time core point detector top level: frame ring, sequencer, divider
// One beat is taken, stored, then the 27 window samples are read from the
// frame ring one per cycle through its single registered read port, counted
// in one shared accumulator, and, for a non-core pixel, the centre is divided
// by the scale in a bit-serial divider. From the accepting step to the next
// step that can accept, a border pixel passes accept, store and output, an
// interior core pixel accept, store, the reads and output, and an interior
// non-core pixel the same plus the division before output. One
// result can wait in the output register while the next beat is processed;
// the sequencer only stalls in its output step if that register is still
// full when the next result is ready. The ring needs no clearing after
// reset; an entry is read only after it was written within the sequence.
module spacetime_core_point_detect_core #(
    parameter int MAX_ROWS    = stcpd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = stcpd_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = stcpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [stcpd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [stcpd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // sample
    input  logic                          s_tuser,   // start_sequence
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // out_row, out_col, scaled_value, window_count
    output logic                          m_tuser    // is_core
);

    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int SLOT  = (1 << RB) * (1 << CB);
    localparam int DEPTH = 3 * SLOT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = RB + CB;

    // configuration registers
    logic [stcpd_pkg::ROW_W-1:0] rows_reg;
    logic [stcpd_pkg::COL_W-1:0] cols_reg;
    logic [stcpd_pkg::THR_W-1:0] thr_reg;
    logic [stcpd_pkg::DIV_W-1:0] div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= stcpd_pkg::ROWS_RESET;
            cols_reg <= stcpd_pkg::COLS_RESET;
            thr_reg  <= stcpd_pkg::THR_RESET;
            div_reg  <= stcpd_pkg::DIV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stcpd_pkg::REG_ROWS: rows_reg <= cfg_data[stcpd_pkg::ROW_W-1:0];
                stcpd_pkg::REG_COLS: cols_reg <= cfg_data[stcpd_pkg::COL_W-1:0];
                stcpd_pkg::REG_THR:  thr_reg  <= cfg_data[stcpd_pkg::THR_W-1:0];
                stcpd_pkg::REG_DIV:  div_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped frame size
    logic [RB:0] rows_c;
    logic [CB:0] cols_c;
    always_comb
    begin
        if ({5'd0, rows_reg} < 13'd3)
            rows_c = (RB+1)'(3);
        else if ({5'd0, rows_reg} > 13'(MAX_ROWS))
            rows_c = (RB+1)'(MAX_ROWS);
        else
            rows_c = (RB+1)'(rows_reg);
        if ({3'd0, cols_reg} < 13'd3)
            cols_c = (CB+1)'(3);
        else if ({3'd0, cols_reg} > 13'(MAX_COLS))
            cols_c = (CB+1)'(MAX_COLS);
        else
            cols_c = (CB+1)'(cols_reg);
    end

    // sequencer state
    stcpd_pkg::state_t state_reg, state_next;
    logic [RB:0]   rpos_reg, rpos_next;
    logic [CB:0]   cpos_reg, cpos_next;
    logic [1:0]    seen_reg, seen_next;
    logic [1:0]    slot_reg, slot_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [4:0]    rd_reg, rd_next;
    logic [4:0]    acc_reg, acc_next;
    logic          zero_reg, zero_next;
    logic [stcpd_pkg::DIV_W-1:0] ctr_reg, ctr_next;
    logic [stcpd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic          core_reg, core_next;
    logic [stcpd_pkg::DIV_W-1:0] scl_reg, scl_next;
    logic          mval_reg, mval_next;
    logic          emit_reg, emit_next;

    stcpd_pkg::div_req_t dreq;
    stcpd_pkg::div_rsp_t drsp;

    // ram port
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [SAMPLE_BITS-1:0] wdata, rdata;

    stcpd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    stcpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stcpd_pkg::ST_IDLE;
            rpos_reg  <= '0;
            cpos_reg  <= '0;
            seen_reg  <= '0;
            slot_reg  <= '0;
            mval_reg  <= 1'b0;
            rd_reg    <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rpos_reg  <= rpos_next;
            cpos_reg  <= cpos_next;
            seen_reg  <= seen_next;
            slot_reg  <= slot_next;
            mval_reg  <= mval_next;
            rd_reg    <= rd_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
        ctr_reg  <= ctr_next;
        cnt_reg  <= cnt_next;
        core_reg <= core_next;
        scl_reg  <= scl_next;
    end

    // read-address generation: rd index = frame*9 + tap
    logic [1:0]   rd_frame;
    logic [3:0]   rd_tap;
    logic [1:0]   rd_slot;
    logic [RB+1:0] rr;
    logic [CB+1:0] rc;
    logic [RB:0]  cr;
    logic [CB:0]  cc;
    logic [2:0]   slot_sum;

    assign cr = rpos_reg - 1'b1;
    assign cc = cpos_reg - 1'b1;

    always_comb
    begin
        if (rd_reg >= 5'd18)
        begin
            rd_frame = 2'd2;
            rd_tap   = 4'(rd_reg - 5'd18);
        end
        else if (rd_reg >= 5'd9)
        begin
            rd_frame = 2'd1;
            rd_tap   = 4'(rd_reg - 5'd9);
        end
        else
        begin
            rd_frame = 2'd0;
            rd_tap   = rd_reg[3:0];
        end
        slot_sum = {1'b0, slot_reg} + {1'b0, rd_frame};
        rd_slot  = (slot_sum >= 3'd3) ? 2'(slot_sum - 3'd3) : slot_sum[1:0];
        rr = (RB+2)'(signed'({2'b00, cr}) + (RB+2)'(stcpd_pkg::tap_dr(rd_tap)));
        rc = (CB+2)'(signed'({2'b00, cc}) + (CB+2)'(stcpd_pkg::tap_dc(rd_tap)));
        raddr = AW'(rd_slot) * AW'(SLOT) + AW'({rr[RB-1:0], rc[CB-1:0]});
    end

    assign wdata = smp_reg;
    assign waddr = AW'(slot_reg) * AW'(SLOT) + AW'({rpos_reg[RB-1:0], cpos_reg[CB-1:0]});

    // tap that arrived this cycle (read was issued the cycle before)
    logic [4:0] got;
    logic [1:0] got_frame;
    logic       got_centre;
    logic       got_mid;
    assign got        = rd_reg - 1'b1;
    assign got_frame  = (got >= 5'd18) ? 2'd2 : ((got >= 5'd9) ? 2'd1 : 2'd0);
    assign got_centre = (got == 5'd0) || (got == 5'd9) || (got == 5'd18);
    assign got_mid    = (got == 5'd18);

    logic interior;
    assign interior = (seen_reg == 2'd2) && (rpos_reg >= (RB+1)'(2)) &&
                      (cpos_reg >= (CB+1)'(2)) && (cr <= rows_c - 2'd2) &&
                      (cc <= cols_c - 2'd2);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rpos_next  = rpos_reg;
        cpos_next  = cpos_reg;
        seen_next  = seen_reg;
        slot_next  = slot_reg;
        smp_next   = smp_reg;
        rd_next    = rd_reg;
        acc_next   = acc_reg;
        zero_next  = zero_reg;
        ctr_next   = ctr_reg;
        cnt_next   = cnt_reg;
        core_next  = core_reg;
        scl_next   = scl_reg;
        mval_next  = mval_reg;
        emit_next  = 1'b0;
        we         = 1'b0;
        s_tready   = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = ctr_reg;
        dreq.divisor  = div_reg;
        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end
        unique case (state_reg)
            stcpd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    smp_next = SAMPLE_BITS'(s_tdata);
                    if (s_tuser)
                    begin
                        rpos_next = '0;
                        cpos_next = '0;
                        seen_next = '0;
                        slot_next = '0;
                    end
                    state_next = stcpd_pkg::ST_WRITE;
                end
            end
            stcpd_pkg::ST_WRITE:
            begin
                we = (rpos_reg < (RB+1)'(MAX_ROWS)) && (cpos_reg < (CB+1)'(MAX_COLS));
                rd_next   = '0;
                acc_next  = '0;
                zero_next = 1'b0;
                if (interior)
                    state_next = stcpd_pkg::ST_READ;
                else
                    state_next = stcpd_pkg::ST_OUT;
            end
            stcpd_pkg::ST_READ:
            begin
                // one read a cycle, rd_reg 0..27; read data is registered
                rd_next = rd_reg + 1'b1;
                if (rd_reg != 5'd0)
                begin
                    if (rdata != '0)
                        acc_next = acc_reg + 1'b1;
                    else if (got_centre)
                        zero_next = 1'b1;
                    if (got_mid)
                        ctr_next = stcpd_pkg::DIV_W'(rdata);
                end
                if (rd_reg == 5'd27)
                begin
                    cnt_next  = (zero_next) ? '0 : acc_next;
                    core_next = ((zero_next) ? 5'd0 : acc_next) >= thr_reg;
                    if ((zero_next ? 5'd0 : acc_next) >= thr_reg)
                    begin
                        scl_next   = '0;
                        emit_next  = 1'b1;
                        state_next = stcpd_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = stcpd_pkg::ST_DIV;
                    end
                end
                if (got_frame == 2'd3)
                    zero_next = 1'b1;
            end
            stcpd_pkg::ST_DIV:
            begin
                dreq.start = (rd_reg == 5'd28);
                rd_next    = 5'd29;
                if (drsp.done)
                begin
                    scl_next   = drsp.quotient;
                    emit_next  = 1'b1;
                    state_next = stcpd_pkg::ST_OUT;
                end
            end
            stcpd_pkg::ST_OUT:
            begin
                if (emit_reg && mval_reg && !m_tready)
                begin
                    // previous result still waiting, hold this one
                    emit_next = 1'b1;
                end
                else
                begin
                    if (emit_reg)
                        mval_next = 1'b1;
                    // advance raster position
                    if (cpos_reg + 1'b1 >= cols_c)
                    begin
                        cpos_next = '0;
                        if (rpos_reg + 1'b1 >= rows_c)
                        begin
                            rpos_next = '0;
                            if (seen_reg != 2'd2)
                                seen_next = seen_reg + 1'b1;
                            slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 1'b1;
                        end
                        else
                            rpos_next = rpos_reg + 1'b1;
                    end
                    else
                        cpos_next = cpos_reg + 1'b1;
                    state_next = stcpd_pkg::ST_IDLE;
                end
            end
            default: state_next = stcpd_pkg::ST_IDLE;
        endcase
    end

    // output beat register, held until taken
    logic                         out_load;
    logic [stcpd_pkg::OROW_W-1:0] orow_reg;
    logic [stcpd_pkg::OCOL_W-1:0] ocol_reg;
    logic [stcpd_pkg::DIV_W-1:0]  oscl_reg;
    logic [stcpd_pkg::CNT_W-1:0]  ocnt_reg;
    logic                         ocore_reg;

    assign out_load = (state_reg == stcpd_pkg::ST_OUT) && emit_reg && (!mval_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            orow_reg  <= stcpd_pkg::OROW_W'(cr);
            ocol_reg  <= stcpd_pkg::OCOL_W'(cc);
            oscl_reg  <= scl_reg;
            ocnt_reg  <= cnt_reg;
            ocore_reg <= core_reg;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {3'b000, ocnt_reg, oscl_reg, ocol_reg, orow_reg};
    assign m_tuser  = ocore_reg;

    // a waiting result beat stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output beat changed while waiting");
    // a core result carries zero scaled value
    assert property (@(posedge clk) disable iff (!rst_n)
        (mval_reg && ocore_reg) |-> (oscl_reg == '0))
        else $error("core result with nonzero value");
    // ring written only right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == stcpd_pkg::ST_WRITE))
        else $error("ring write outside write step");

endmodule
